[rtl/phr_pkg.sv]
// ----------------------------------------------------------------------------
// phr_pkg
// Shared types and constants for the per-channel history ring.
// ----------------------------------------------------------------------------
`default_nettype none

package phr_pkg;

    localparam int CMD_W       = 2;
    localparam int CHAN_W      = 7;
    localparam int AGO_W       = 6;
    localparam int CNT_W       = 7;
    localparam int DEPTH_W     = 7;
    localparam int IO_SAMPLE_W = 64;

    localparam logic [CMD_W-1:0] CMD_RECORD    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ      = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR     = 2'd2;
    localparam logic [CMD_W-1:0] CMD_CLEAR_ALL = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_META,
        ST_STORE,
        ST_DONE
    } t_state;

endpackage

`default_nettype wire

[rtl/phr_ram.sv]
// ----------------------------------------------------------------------------
// phr_ram
// Simple dual-port memory: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module phr_ram #(
    parameter  int DATA_W = 8,
    parameter  int DEPTH  = 2,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [DATA_W-1:0] i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[rtl/phr_meta.sv]
// ----------------------------------------------------------------------------
// phr_meta
// Channel table: head pointer and fill count per channel, with a valid bit
// per channel so that clear and clear-all take effect at once.
// ----------------------------------------------------------------------------
`default_nettype none

module phr_meta #(
    parameter  int CHANNELS = 64,
    parameter  int HEAD_W   = 6,
    localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_rd_en,
    input  wire logic [CH_W-1:0]            i_rd_ch,
    input  wire logic                       i_wr_en,
    input  wire logic [CH_W-1:0]            i_wr_ch,
    input  wire logic [HEAD_W-1:0]          i_wr_head,
    input  wire logic [phr_pkg::CNT_W-1:0]  i_wr_cnt,
    input  wire logic                       i_clr_en,
    input  wire logic [CH_W-1:0]            i_clr_ch,
    input  wire logic                       i_clr_all,
    output logic      [HEAD_W-1:0]          o_rd_head,
    output logic      [phr_pkg::CNT_W-1:0]  o_rd_cnt
);
    import phr_pkg::*;

    localparam int ENT_W = HEAD_W + CNT_W;

    logic [CHANNELS-1:0] r_vld;
    logic                r_rd_vld;
    logic [ENT_W-1:0]    rd_data;

    phr_ram #(
        .DATA_W (ENT_W),
        .DEPTH  (CHANNELS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_wr_en),
        .i_waddr (i_wr_ch),
        .i_wdata ({i_wr_head, i_wr_cnt}),
        .i_re    (i_rd_en),
        .i_raddr (i_rd_ch),
        .o_rdata (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_clr_all) begin
            r_vld <= '0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_ch] <= 1'b1;
            end
            if (i_clr_en) begin
                r_vld[i_clr_ch] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else if (i_rd_en) begin
            r_rd_vld <= r_vld[i_rd_ch];
        end
    end

    assign o_rd_head = r_rd_vld ? rd_data[ENT_W-1:CNT_W] : '0;
    assign o_rd_cnt  = r_rd_vld ? rd_data[CNT_W-1:0]     : '0;

endmodule

`default_nettype wire

[rtl/per_channel_history_ring.sv]
// ----------------------------------------------------------------------------
// per_channel_history_ring
// Per-channel circular sample history with record, read and clear commands.
// ----------------------------------------------------------------------------
// Each channel keeps its last depth_in_use samples in one sample memory; a
// channel table holds every channel's head pointer and fill count. The table
// is read on acceptance; ST_META updates it and stores a recorded sample;
// ST_DONE posts the result once the output register is free and may accept
// the next item. A read that returns a sample passes ST_STORE between them.
// Results leave through an output register, so the next item is taken while
// a result still waits. Clears act on per-channel valid bits at once; there
// is no clearing pass after reset. Write depth_in_use only while idle: a
// larger value clears every channel, a smaller or equal one is ignored.
// ----------------------------------------------------------------------------
`default_nettype none

module per_channel_history_ring #(
    parameter int CHANNELS    = 64,
    parameter int MAX_DEPTH   = 64,
    parameter int SAMPLE_BITS = 64
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [phr_pkg::DEPTH_W-1:0]      i_cfg_data,
    input  wire logic                             i_valid,
    output logic                                  o_ready,
    input  wire logic [phr_pkg::CMD_W-1:0]        i_command,
    input  wire logic [phr_pkg::CHAN_W-1:0]       i_channel,
    input  wire logic [phr_pkg::AGO_W-1:0]        i_ago,
    input  wire logic                             i_sample_valid,
    input  wire logic [phr_pkg::IO_SAMPLE_W-1:0]  i_sample,
    output logic                                  o_valid,
    input  wire logic                             i_ready,
    output logic      [phr_pkg::CNT_W-1:0]        o_fill_count,
    output logic      [phr_pkg::IO_SAMPLE_W-1:0]  o_sample_out,
    output logic                                  o_ok
);
    import phr_pkg::*;

    localparam int DEPTH_CAP = (MAX_DEPTH > 127) ? 127 : MAX_DEPTH;
    localparam int HEAD_W    = $clog2(DEPTH_CAP);
    localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int STORE_D   = CHANNELS * MAX_DEPTH;
    localparam int ADDR_W    = $clog2(STORE_D);
    localparam int EXT_W     = 9;

    t_state                  r_state, n_state;
    logic [CMD_W-1:0]        r_cmd, n_cmd;
    logic [CHAN_W-1:0]       r_ch, n_ch;
    logic [AGO_W-1:0]        r_ago, n_ago;
    logic                    r_svld, n_svld;
    logic [SAMPLE_BITS-1:0]  r_sample, n_sample;
    logic [DEPTH_W-1:0]      r_depth;
    logic [CNT_W-1:0]        r_res_cnt, n_res_cnt;
    logic                    r_res_ok, n_res_ok;
    logic                    r_res_rd, n_res_rd;
    logic                    r_o_valid, n_o_valid;
    logic [CNT_W-1:0]        r_o_fill, n_o_fill;
    logic [SAMPLE_BITS-1:0]  r_o_sample, n_o_sample;
    logic                    r_o_ok, n_o_ok;

    logic [DEPTH_W-1:0]      cfg_depth;
    logic                    cfg_grow;

    logic                    meta_rd_en;
    logic                    meta_wr_en;
    logic                    meta_clr_en;
    logic                    meta_clr_all;
    logic [HEAD_W-1:0]       meta_head;
    logic [CNT_W-1:0]        meta_cnt;
    logic [HEAD_W-1:0]       new_head;
    logic [CNT_W-1:0]        new_cnt;

    logic                    store_we;
    logic                    store_re;
    logic [ADDR_W-1:0]       store_waddr;
    logic [ADDR_W-1:0]       store_raddr;
    logic [SAMPLE_BITS-1:0]  store_rdata;

    logic                    chan_ok;
    logic [CH_W-1:0]         ch_idx;
    logic [EXT_W-1:0]        head_inc;
    logic [EXT_W-1:0]        pos_raw;
    logic [HEAD_W-1:0]       pos;
    logic [ADDR_W-1:0]       ch_base;
    logic                    out_free;
    logic                    fsm_clr_all;

    // Config: clamp to 1..DEPTH_CAP, grow only.
    always_comb begin
        cfg_depth = i_cfg_data;
        if (cfg_depth == '0) begin
            cfg_depth = DEPTH_W'(1);
        end
        if (cfg_depth > DEPTH_W'(DEPTH_CAP)) begin
            cfg_depth = DEPTH_W'(DEPTH_CAP);
        end
        cfg_grow = i_cfg_valid && (cfg_depth > r_depth);
    end

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth <= DEPTH_W'(1);
        end else if (cfg_grow) begin
            r_depth <= cfg_depth;
        end
    end

    assign ch_idx  = r_ch[CH_W-1:0];
    assign chan_ok = ({1'b0, r_ch} < (CHAN_W + 1)'(CHANNELS));
    assign ch_base = ADDR_W'(ch_idx) * ADDR_W'(MAX_DEPTH);

    always_comb begin
        head_inc = EXT_W'(meta_head) + EXT_W'(1);
        if (head_inc >= EXT_W'(r_depth)) begin
            new_head = '0;
        end else begin
            new_head = head_inc[HEAD_W-1:0];
        end
        if (meta_cnt < r_depth) begin
            new_cnt = meta_cnt + CNT_W'(1);
        end else begin
            new_cnt = meta_cnt;
        end
        pos_raw = EXT_W'(meta_head) - EXT_W'(1) - EXT_W'(r_ago);
        if (pos_raw[EXT_W-1]) begin
            pos_raw = pos_raw + EXT_W'(r_depth);
        end
        pos = pos_raw[HEAD_W-1:0];
    end

    assign store_waddr = ch_base + ADDR_W'(meta_head);
    assign store_raddr = ch_base + ADDR_W'(pos);
    assign meta_clr_all = fsm_clr_all || cfg_grow;
    assign out_free     = !r_o_valid || i_ready;

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_ch        = r_ch;
        n_ago       = r_ago;
        n_svld      = r_svld;
        n_sample    = r_sample;
        n_res_cnt   = r_res_cnt;
        n_res_ok    = r_res_ok;
        n_res_rd    = r_res_rd;
        n_o_valid   = r_o_valid && !i_ready;
        n_o_fill    = r_o_fill;
        n_o_sample  = r_o_sample;
        n_o_ok      = r_o_ok;
        o_ready     = 1'b0;
        meta_rd_en  = 1'b0;
        meta_wr_en  = 1'b0;
        meta_clr_en = 1'b0;
        fsm_clr_all = 1'b0;
        store_we    = 1'b0;
        store_re    = 1'b0;

        case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
            end
            ST_META: begin
                n_res_cnt = '0;
                n_res_ok  = 1'b0;
                n_res_rd  = 1'b0;
                n_state   = ST_DONE;
                case (r_cmd)
                    CMD_RECORD: begin
                        if (chan_ok) begin
                            n_res_cnt = meta_cnt;
                            if (r_svld) begin
                                store_we   = 1'b1;
                                meta_wr_en = 1'b1;
                                n_res_cnt  = new_cnt;
                                n_res_ok   = 1'b1;
                            end
                        end
                    end
                    CMD_READ: begin
                        if (chan_ok) begin
                            n_res_cnt = meta_cnt;
                            if ({1'b0, r_ago} < meta_cnt) begin
                                store_re = 1'b1;
                                n_res_ok = 1'b1;
                                n_res_rd = 1'b1;
                                n_state  = ST_STORE;
                            end
                        end
                    end
                    CMD_CLEAR: begin
                        if (chan_ok) begin
                            meta_clr_en = 1'b1;
                            n_res_ok    = 1'b1;
                        end
                    end
                    default: begin
                        fsm_clr_all = 1'b1;
                        n_res_ok    = 1'b1;
                    end
                endcase
            end
            ST_STORE: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    n_o_valid  = 1'b1;
                    n_o_fill   = r_res_cnt;
                    n_o_ok     = r_res_ok;
                    n_o_sample = r_res_rd ? store_rdata : '0;
                    o_ready    = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (o_ready && i_valid) begin
            n_cmd      = i_command;
            n_ch       = i_channel;
            n_ago      = i_ago;
            n_svld     = i_sample_valid;
            n_sample   = i_sample[SAMPLE_BITS-1:0];
            meta_rd_en = 1'b1;
            n_state    = ST_META;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_ch       <= n_ch;
        r_ago      <= n_ago;
        r_svld     <= n_svld;
        r_sample   <= n_sample;
        r_res_cnt  <= n_res_cnt;
        r_res_ok   <= n_res_ok;
        r_res_rd   <= n_res_rd;
        r_o_fill   <= n_o_fill;
        r_o_sample <= n_o_sample;
        r_o_ok     <= n_o_ok;
    end

    phr_meta #(
        .CHANNELS (CHANNELS),
        .HEAD_W   (HEAD_W)
    ) u_meta (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (meta_rd_en),
        .i_rd_ch   (i_channel[CH_W-1:0]),
        .i_wr_en   (meta_wr_en),
        .i_wr_ch   (ch_idx),
        .i_wr_head (new_head),
        .i_wr_cnt  (new_cnt),
        .i_clr_en  (meta_clr_en),
        .i_clr_ch  (ch_idx),
        .i_clr_all (meta_clr_all),
        .o_rd_head (meta_head),
        .o_rd_cnt  (meta_cnt)
    );

    phr_ram #(
        .DATA_W (SAMPLE_BITS),
        .DEPTH  (STORE_D)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (store_we),
        .i_waddr (store_waddr),
        .i_wdata (r_sample),
        .i_re    (store_re),
        .i_raddr (store_raddr),
        .o_rdata (store_rdata)
    );

    assign o_valid      = r_o_valid;
    assign o_fill_count = r_o_fill;
    assign o_sample_out = IO_SAMPLE_W'(r_o_sample);
    assign o_ok         = r_o_ok;

endmodule

`default_nettype wire
